// ----- hw/rtl/pabt_pkg.sv -----
// Shared types and constants of the packet acknowledgement tracker.
package pabt_pkg;

  localparam int SENT_DEPTH_DEF = 256;
  localparam int SEQ_W          = 16;
  localparam int TICK_W         = 32;
  localparam int MASK_W         = 32;
  localparam int TYPE_W         = 8;
  localparam int RTT_W          = 40;
  localparam int IN_DATA_W      = 104;
  localparam int OUT_DATA_W     = 128;
  localparam int STEP_W         = 6;
  localparam int DIV_STEPS      = 6;

  localparam logic OP_SEND  = 1'b0;
  localparam logic OP_RECV  = 1'b1;
  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_ACK = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEND,
    ST_RX_UPD,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic clr;
    logic load_in;
    logic send_hdr;
    logic rx_upd;
    logic mod_step;
    logic rd;
    logic advance;
    logic ack_start;
    logic div_step;
    logic push_pend;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic mod_last;
    logic step_active;
    logic last_step;
    logic hit;
    logic rtt_zero;
    logic div_last;
    logic pend_valid;
  } sts_t;

endpackage

// ----- hw/rtl/pabt_ctrl.sv -----
// Controller state machine of the packet acknowledgement tracker.
module pabt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_op,
  output logic          in_tready,
  input  pabt_pkg::sts_t sts,
  output pabt_pkg::cmd_t cmd
);
  import pabt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = (in_op == OP_SEND) ? ST_SEND : ST_RX_UPD;
        end
      end
      ST_SEND: begin
        if (sts.out_free) begin
          cmd.send_hdr = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RX_UPD: begin
        cmd.rx_upd = 1'b1;
        state_nxt  = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (sts.step_active) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CHECK;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = sts.last_step ? ST_FLUSH : ST_READ;
        end
      end
      ST_CHECK: begin
        if (sts.hit) begin
          cmd.ack_start = 1'b1;
          state_nxt     = sts.rtt_zero ? ST_EMIT : ST_DIV;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = sts.last_step ? ST_FLUSH : ST_READ;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hold the new report back until the older one has a slot
        if (!sts.pend_valid || sts.out_free) begin
          cmd.push_pend = 1'b1;
          cmd.advance   = 1'b1;
          state_nxt     = sts.last_step ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_nxt = ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

// ----- hw/rtl/pabt_dp.sv -----
// Datapath of the packet acknowledgement tracker: sent store, sequence state, RTT divider.
module pabt_dp #(
  parameter int SENT_DEPTH = pabt_pkg::SENT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pabt_pkg::cmd_t                cmd,
  output pabt_pkg::sts_t                sts,
  input  logic [pabt_pkg::TICK_W-1:0]   in_now_ticks,
  input  logic [pabt_pkg::TYPE_W-1:0]   in_pkt_type,
  input  logic [pabt_pkg::SEQ_W-1:0]    in_rx_sequence,
  input  logic [pabt_pkg::SEQ_W-1:0]    in_rx_ack,
  input  logic [pabt_pkg::MASK_W-1:0]   in_rx_ack_mask,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic                          out_last,
  output logic [pabt_pkg::SEQ_W-1:0]    out_hdr_sequence,
  output logic [pabt_pkg::SEQ_W-1:0]    out_hdr_ack,
  output logic [pabt_pkg::MASK_W-1:0]   out_hdr_ack_mask,
  output logic [pabt_pkg::TYPE_W-1:0]   out_hdr_type,
  output logic [pabt_pkg::SEQ_W-1:0]    out_rpt_seq,
  output logic [pabt_pkg::RTT_W-1:0]    out_rtt_estimate
);
  import pabt_pkg::*;

  localparam int AW       = (SENT_DEPTH > 1) ? $clog2(SENT_DEPTH) : 1;
  localparam int WRAP_IDX = 65535 % SENT_DEPTH;
  localparam int WORD_W   = 1 + TICK_W + SEQ_W;
  localparam int NUM_W    = 8 * DIV_STEPS;

  // captured item
  logic [TICK_W-1:0] now_r;
  logic [TYPE_W-1:0] type_r;
  logic [SEQ_W-1:0]  rseq_r, rack_r;
  logic [MASK_W-1:0] rmask_r;

  // connection state
  logic [SEQ_W-1:0]  tx_seq_r, remote_r;
  logic [AW-1:0]     local_idx_r;
  logic [MASK_W-1:0] mask_r, mask_nxt;
  logic [RTT_W-1:0]  rtt_r;
  logic [AW-1:0]     clr_idx_r;

  // walk over the acknowledged sequences
  logic [STEP_W-1:0] cnt_r;
  logic [SEQ_W-1:0]  cur_seq_r;
  logic [AW-1:0]     cur_idx_r;
  logic [AW-1:0]     mod_rem_r, mod_rem_nxt;
  logic              mod_ph_r;

  // store
  logic [WORD_W-1:0] mem [SENT_DEPTH];
  logic [WORD_W-1:0] rdata_r;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  // divider by ten
  logic [NUM_W-1:0]  div_num_r;
  logic [3:0]        div_rem_r, div_rem_nxt;
  logic [RTT_W-1:0]  div_q_r, div_q_nxt;
  logic [2:0]        div_cnt_r;

  // pending report and output register
  logic              pend_valid_r;
  logic [SEQ_W-1:0]  pend_seq_r;
  logic [RTT_W-1:0]  pend_rtt_r;
  logic              out_valid_r, out_kind_r, out_last_r;
  logic [SEQ_W-1:0]  out_hseq_r, out_hack_r, out_aseq_r;
  logic [MASK_W-1:0] out_hmask_r;
  logic [TYPE_W-1:0] out_htype_r;
  logic [RTT_W-1:0]  out_rtt_r;

  logic [SEQ_W-1:0]  rd_seq;
  logic [TICK_W-1:0] rd_time;
  logic              rd_acked;
  logic [RTT_W-1:0]  sample;
  logic [NUM_W-1:0]  numer;
  logic              out_free;

  assign rd_seq   = rdata_r[SEQ_W-1:0];
  assign rd_time  = rdata_r[SEQ_W+TICK_W-1:SEQ_W];
  assign rd_acked = rdata_r[WORD_W-1];
  assign sample   = {now_r - rd_time, 8'd0};
  assign numer    = {{(NUM_W-RTT_W-3){1'b0}}, rtt_r, 3'd0}
                  + NUM_W'(rtt_r) + NUM_W'(sample) + NUM_W'(5);
  assign out_free = !out_valid_r || out_tready;

  assign sts.clr_last    = (clr_idx_r == AW'(SENT_DEPTH - 1));
  assign sts.out_free    = out_free;
  assign sts.mod_last    = mod_ph_r;
  assign sts.step_active = (cnt_r == '0) || rmask_r[5'(cnt_r - STEP_W'(1))];
  assign sts.last_step   = (cnt_r == STEP_W'(32));
  assign sts.hit         = (rd_seq == cur_seq_r) && !rd_acked;
  assign sts.rtt_zero    = (rtt_r == '0);
  assign sts.div_last    = (div_cnt_r == 3'(DIV_STEPS - 1));
  assign sts.pend_valid  = pend_valid_r;

  // receive window update with 16-bit wraparound
  always_comb begin
    logic [SEQ_W-1:0] d_new, d_old;
    logic             newer;
    d_new    = rseq_r - remote_r;
    d_old    = remote_r - rseq_r;
    newer    = (d_new != '0) &&
               ((d_new < 16'h8000) || ((d_new == 16'h8000) && (rseq_r > remote_r)));
    mask_nxt = mask_r;
    if (newer) begin
      if (d_new <= 16'd32) begin
        mask_nxt = ((d_new < 16'd32) ? (mask_r << d_new[4:0]) : '0)
                 | (MASK_W'(1) << 5'(d_new - 16'd1));
      end else begin
        mask_nxt = '0;
      end
    end else if ((d_old != '0) && (d_old <= 16'd32)) begin
      mask_nxt = mask_r | (MASK_W'(1) << 5'(d_old - 16'd1));
    end
  end

  // eight bits of rx_ack mod depth per cycle
  always_comb begin
    logic [7:0]  bits;
    logic [AW:0] t;
    bits        = mod_ph_r ? rack_r[7:0] : rack_r[15:8];
    mod_rem_nxt = mod_rem_r;
    for (int k = 7; k >= 0; k--) begin
      t = {mod_rem_nxt, bits[k]};
      if (t >= (AW+1)'(SENT_DEPTH)) t = t - (AW+1)'(SENT_DEPTH);
      mod_rem_nxt = t[AW-1:0];
    end
  end

  // eight quotient bits of the divide by ten per cycle
  always_comb begin
    logic [4:0] t;
    div_rem_nxt = div_rem_r;
    div_q_nxt   = div_q_r;
    for (int k = 7; k >= 0; k--) begin
      t = {div_rem_nxt, div_num_r[NUM_W-8+k]};
      if (t >= 5'd10) begin
        t         = t - 5'd10;
        div_q_nxt = {div_q_nxt[RTT_W-2:0], 1'b1};
      end else begin
        div_q_nxt = {div_q_nxt[RTT_W-2:0], 1'b0};
      end
      div_rem_nxt = t[3:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_idx_r;
    wdata = {1'b1, rd_time, rd_seq};
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      wdata = '0;
    end else if (cmd.send_hdr) begin
      we    = 1'b1;
      waddr = local_idx_r;
      wdata = {1'b0, now_r, tx_seq_r};
    end else if (cmd.ack_start) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) rdata_r <= mem[cur_idx_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r   <= in_now_ticks;
      type_r  <= in_pkt_type;
      rseq_r  <= in_rx_sequence;
      rack_r  <= in_rx_ack;
      rmask_r <= in_rx_ack_mask;
    end
    if (cmd.ack_start) begin
      div_num_r <= numer;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_num_r <= div_num_r << 8;
      div_rem_r <= div_rem_nxt;
      div_q_r   <= div_q_nxt;
    end
    if (cmd.push_pend) begin
      pend_seq_r <= cur_seq_r;
      pend_rtt_r <= rtt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_seq_r     <= '0;
      local_idx_r  <= '0;
      remote_r     <= '0;
      mask_r       <= '0;
      rtt_r        <= '0;
      clr_idx_r    <= '0;
      cnt_r        <= '0;
      cur_seq_r    <= '0;
      cur_idx_r    <= '0;
      mod_rem_r    <= '0;
      mod_ph_r     <= 1'b0;
      div_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.clr) clr_idx_r <= clr_idx_r + AW'(1);
      if (cmd.send_hdr) begin
        tx_seq_r <= tx_seq_r + 16'd1;
        if (tx_seq_r == 16'hFFFF || local_idx_r == AW'(SENT_DEPTH - 1)) begin
          local_idx_r <= '0;
        end else begin
          local_idx_r <= local_idx_r + AW'(1);
        end
      end
      if (cmd.rx_upd) begin
        mask_r    <= mask_nxt;
        cnt_r     <= '0;
        cur_seq_r <= rack_r;
        mod_rem_r <= '0;
        mod_ph_r  <= 1'b0;
        if (((rseq_r - remote_r) != '0) &&
            (((rseq_r - remote_r) < 16'h8000) ||
             (((rseq_r - remote_r) == 16'h8000) && (rseq_r > remote_r)))) begin
          remote_r <= rseq_r;
        end
      end
      if (cmd.mod_step) begin
        mod_rem_r <= mod_rem_nxt;
        mod_ph_r  <= 1'b1;
        if (mod_ph_r) cur_idx_r <= mod_rem_nxt;
      end
      if (cmd.advance) begin
        cnt_r     <= cnt_r + STEP_W'(1);
        cur_seq_r <= cur_seq_r - 16'd1;
        if (cur_seq_r == '0) begin
          cur_idx_r <= AW'(WRAP_IDX);
        end else if (cur_idx_r == '0) begin
          cur_idx_r <= AW'(SENT_DEPTH - 1);
        end else begin
          cur_idx_r <= cur_idx_r - AW'(1);
        end
      end
      if (cmd.ack_start) begin
        div_cnt_r <= '0;
        if (rtt_r == '0) rtt_r <= sample;
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r + 3'd1;
        if (sts.div_last) rtt_r <= div_q_nxt;
      end
      if (cmd.push_pend) pend_valid_r <= 1'b1;
      else if (cmd.flush) pend_valid_r <= 1'b0;
      if (cmd.send_hdr || cmd.flush || (cmd.push_pend && pend_valid_r)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.send_hdr) begin
      out_kind_r  <= KIND_HDR;
      out_last_r  <= 1'b1;
      out_hseq_r  <= tx_seq_r;
      out_hack_r  <= remote_r;
      out_hmask_r <= mask_r;
      out_htype_r <= type_r;
      out_aseq_r  <= '0;
      out_rtt_r   <= '0;
    end else if (cmd.flush || (cmd.push_pend && pend_valid_r)) begin
      out_kind_r  <= KIND_ACK;
      out_last_r  <= cmd.flush;
      out_hseq_r  <= '0;
      out_hack_r  <= '0;
      out_hmask_r <= '0;
      out_htype_r <= '0;
      out_aseq_r  <= pend_seq_r;
      out_rtt_r   <= pend_rtt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_last         = out_last_r;
  assign out_hdr_sequence = out_hseq_r;
  assign out_hdr_ack      = out_hack_r;
  assign out_hdr_ack_mask = out_hmask_r;
  assign out_hdr_type     = out_htype_r;
  assign out_rpt_seq      = out_aseq_r;
  assign out_rtt_estimate = out_rtt_r;

endmodule

// ----- hw/rtl/packet_ack_bitfield_tracker_core.sv -----
// Top level of the packet acknowledgement tracker.
//
// Input stream: one beat per operation. in_tuser selects send (0) or receive (1).
// A send beat yields one header beat on the output stream, tlast set.
// A receive beat updates the receive window, then walks rx_ack and the 32
// sequences flagged in the 32-bit rx_ack_mask against the sent store and
// yields one report beat per newly acknowledged packet (possibly none);
// tlast marks the final one. out_tuser tells header (0) from report (1).
// Processing: each hit folds its sample into the RTT estimate through a
// divide by ten; a hit with no estimate yet skips the divide and takes the
// sample as the estimate. One item is in work at a time.
// Reset: a clearing pass writes every one of the SENT_DEPTH store entries,
// one a cycle; no beat is accepted until it ends. All sequence state and the
// RTT estimate return to zero.
// Stall: the output register holds its beat until out_tready; one further
// report waits in a pending register and the walk pauses behind it.
module packet_ack_bitfield_tracker_core #(
  parameter int SENT_DEPTH = pabt_pkg::SENT_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // now_ticks[31:0], pkt_type[39:32], rx_sequence[55:40], rx_ack[71:56],
  // rx_ack_mask[103:72]
  input  logic [pabt_pkg::IN_DATA_W-1:0]    in_tdata,
  // op[0]
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // hdr_sequence[15:0], hdr_ack[31:16], hdr_ack_mask[63:32], hdr_type[71:64],
  // newly acknowledged sequence[87:72], rtt_estimate[127:88]
  output logic [pabt_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_kind[0]
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import pabt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic [SEQ_W-1:0]  hdr_sequence, hdr_ack, rpt_seq;
  logic [MASK_W-1:0] hdr_ack_mask;
  logic [TYPE_W-1:0] hdr_type;
  logic [RTT_W-1:0]  rtt_estimate;

  pabt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pabt_dp #(
    .SENT_DEPTH (SENT_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_now_ticks     (in_tdata[31:0]),
    .in_pkt_type      (in_tdata[39:32]),
    .in_rx_sequence   (in_tdata[55:40]),
    .in_rx_ack        (in_tdata[71:56]),
    .in_rx_ack_mask   (in_tdata[103:72]),
    .out_tready       (out_tready),
    .out_valid        (out_tvalid),
    .out_kind         (out_tuser),
    .out_last         (out_tlast),
    .out_hdr_sequence (hdr_sequence),
    .out_hdr_ack      (hdr_ack),
    .out_hdr_ack_mask (hdr_ack_mask),
    .out_hdr_type     (hdr_type),
    .out_rpt_seq      (rpt_seq),
    .out_rtt_estimate (rtt_estimate)
  );

  assign out_tdata = {rtt_estimate, rpt_seq, hdr_type, hdr_ack_mask, hdr_ack, hdr_sequence};

  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_HDR) |-> out_tlast)
    else $error("header beat without tlast");

  a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_ACK) |-> (out_tdata[71:0] == '0))
    else $error("report beat carries header fields");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.send_hdr || cmd.flush || (cmd.push_pend && sts.pend_valid)) |-> sts.out_free)
    else $error("output register overwritten");

endmodule

// ----- tb/tb_packet_ack_bitfield_tracker_core.sv -----
// Self-checking testbench of the packet acknowledgement tracker core.
module tb_packet_ack_bitfield_tracker_core;
  import pabt_pkg::*;

  localparam int DEPTH     = SENT_DEPTH_DEF;
  localparam int N_RANDOM  = 350;
  localparam int N_CALM    = 60;

  typedef struct {
    logic              kind;
    logic [SEQ_W-1:0]  hseq;
    logic [SEQ_W-1:0]  hack;
    logic [MASK_W-1:0] hmask;
    logic [TYPE_W-1:0] htype;
    logic [SEQ_W-1:0]  aseq;
    logic [RTT_W-1:0]  rtt;
    logic              last;
  } beat_t;

  typedef struct {
    logic              op;
    logic [TICK_W-1:0] now;
    logic [TYPE_W-1:0] ptype;
    logic [SEQ_W-1:0]  rseq;
    logic [SEQ_W-1:0]  rack;
    logic [MASK_W-1:0] rmask;
    bit                typed;
    logic [SEQ_W-1:0]  t_seq;
    logic [SEQ_W-1:0]  t_ack;
    logic [MASK_W-1:0] t_mask;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  logic [OUT_DATA_W-1:0] out_tdata;

  // tracker mirror
  logic [SEQ_W-1:0]  tx_seq, peer_seq;
  logic [MASK_W-1:0] peer_mask;
  logic [SEQ_W-1:0]  store_seq [DEPTH];
  logic [TICK_W-1:0] store_time [DEPTH];
  bit                store_acked [DEPTH];
  logic [RTT_W-1:0]  rtt_avg;

  beat_t pending_beats[$];
  int    n_errors;
  bit    calm;
  int    stall_left;
  row_t  rows[$];

  packet_ack_bitfield_tracker_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic bit seq_ahead(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] ab, ba;
    ab = a - b;
    ba = b - a;
    return ((a > b) && (ab <= 16'd32768)) || ((a < b) && (ba > 16'd32768));
  endfunction

  task automatic try_acknowledge(input logic [SEQ_W-1:0] s, input logic [TICK_W-1:0] now,
                                 inout int n);
    int idx;
    logic [TICK_W-1:0] dt;
    logic [63:0] sample, acc;
    beat_t b;
    idx = s % DEPTH;
    if (store_seq[idx] != s || store_acked[idx]) return;
    store_acked[idx] = 1'b1;
    dt = now - store_time[idx];
    sample = {24'd0, dt, 8'd0};
    if (rtt_avg == '0) acc = sample;
    else acc = (64'd9 * {24'd0, rtt_avg} + sample + 64'd5) / 64'd10;
    rtt_avg = acc[RTT_W-1:0];
    b = '{KIND_ACK, '0, '0, '0, '0, s, rtt_avg, 1'b0};
    pending_beats.push_back(b);
    n++;
  endtask

  task automatic predict_item(input row_t r);
    int idx, n;
    logic [SEQ_W-1:0] d;
    beat_t b;
    if (r.op == OP_SEND) begin
      b = '{KIND_HDR, tx_seq, peer_seq, peer_mask, r.ptype, '0, '0, 1'b1};
      if (r.typed) begin
        b.hseq = r.t_seq; b.hack = r.t_ack; b.hmask = r.t_mask;
      end
      pending_beats.push_back(b);
      idx = tx_seq % DEPTH;
      store_seq[idx] = tx_seq;
      store_time[idx] = r.now;
      store_acked[idx] = 1'b0;
      tx_seq = tx_seq + 1'b1;
      return;
    end
    if (seq_ahead(r.rseq, peer_seq)) begin
      d = r.rseq - peer_seq;
      if (d <= 32) peer_mask = (d < 32 ? (peer_mask << d) : '0) | (32'd1 << (d - 1));
      else peer_mask = '0;
      peer_seq = r.rseq;
    end else begin
      d = peer_seq - r.rseq;
      if (d > 0 && d <= 32) peer_mask |= 32'd1 << (d - 1);
    end
    n = 0;
    try_acknowledge(r.rack, r.now, n);
    for (int i = 0; i < 32; i++)
      if (r.rmask[i]) try_acknowledge(r.rack - 16'd1 - i[SEQ_W-1:0], r.now, n);
    if (n > 0) pending_beats[$].last = 1'b1;
  endtask

  // drive one beat, idling first at random
  task automatic drive_item(input row_t r);
    if (!calm && $urandom_range(0, 2) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tuser  = r.op;
    in_tdata  = {r.rmask, r.rack, r.rseq, r.ptype, r.now};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_item(r);
    @(negedge clk);
  endtask

  function automatic row_t send_row(logic [TICK_W-1:0] now, logic [TYPE_W-1:0] t);
    row_t r;
    r = '{OP_SEND, now, t, '0, '0, '0, 1'b0, '0, '0, '0};
    return r;
  endfunction

  function automatic row_t recv_row(logic [TICK_W-1:0] now, logic [SEQ_W-1:0] rs,
                                    logic [SEQ_W-1:0] ra, logic [MASK_W-1:0] m);
    row_t r;
    r = '{OP_RECV, now, '0, rs, ra, m, 1'b0, '0, '0, '0};
    return r;
  endfunction

  function automatic row_t hdr_row(logic [TICK_W-1:0] now, logic [TYPE_W-1:0] t,
                                   logic [SEQ_W-1:0] s, logic [SEQ_W-1:0] a,
                                   logic [MASK_W-1:0] m);
    row_t r;
    r = '{OP_SEND, now, t, '0, '0, '0, 1'b1, s, a, m};
    return r;
  endfunction

  always @(negedge clk) begin
    if (calm) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready = 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_tready = 1'b0;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_beats.size() == 0) begin
        $error("unexpected beat: tuser %0b tdata %h", out_tuser, out_tdata);
        n_errors++;
      end else begin
        e = pending_beats.pop_front();
        if (out_tuser !== e.kind) begin
          $error("out_kind: expected %0h actual %0h", e.kind, out_tuser); n_errors++;
        end
        if (out_tdata[15:0] !== e.hseq) begin
          $error("hdr_sequence: expected %0h actual %0h", e.hseq, out_tdata[15:0]);
          n_errors++;
        end
        if (out_tdata[31:16] !== e.hack) begin
          $error("hdr_ack: expected %0h actual %0h", e.hack, out_tdata[31:16]);
          n_errors++;
        end
        if (out_tdata[63:32] !== e.hmask) begin
          $error("hdr_ack_mask: expected %0h actual %0h", e.hmask, out_tdata[63:32]);
          n_errors++;
        end
        if (out_tdata[71:64] !== e.htype) begin
          $error("hdr_type: expected %0h actual %0h", e.htype, out_tdata[71:64]);
          n_errors++;
        end
        if (out_tdata[87:72] !== e.aseq) begin
          $error("acked sequence: expected %0h actual %0h", e.aseq, out_tdata[87:72]);
          n_errors++;
        end
        if (out_tdata[127:88] !== e.rtt) begin
          $error("rtt_estimate: expected %0h actual %0h", e.rtt, out_tdata[127:88]);
          n_errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0h actual %0h", e.last, out_tlast); n_errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [TICK_W-1:0] clock_ticks;
    logic [SEQ_W-1:0] rs, ra;
    logic [MASK_W-1:0] m;
    int pick;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tuser = 1'b0; in_tdata = '0;
    out_tready = 1'b0; n_errors = 0; calm = 1'b0; stall_left = 0;
    tx_seq = '0; peer_seq = '0; peer_mask = '0; rtt_avg = '0;
    for (int i = 0; i < DEPTH; i++) begin
      store_seq[i] = '0; store_time[i] = '0; store_acked[i] = 1'b0;
    end

    // after reset, extremes, window moves, stale slot and wrapped time
    rows.push_back(hdr_row(32'd0, 8'h00, 16'd0, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd100, 16'd0, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd150, 16'd0, 16'd0, 32'd0));
    rows.push_back(hdr_row(32'd200, 8'hff, 16'd1, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd1000, 16'd5, 16'd1, 32'hffff_ffff));
    rows.push_back(hdr_row(32'hffff_ffff, 8'h5a, 16'd2, 16'd5, 32'h10));
    rows.push_back(recv_row(32'd1100, 16'd3, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd1200, 16'd40, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd1300, 16'd32808, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd1400, 16'd32775, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd1500, 16'd32840, 16'd0, 32'd0));
    rows.push_back(recv_row(32'd1600, 16'd32840, 16'd0, 32'd0));
    rows.push_back(send_row(32'hffff_ff00, 8'h01));
    rows.push_back(send_row(32'hffff_ff10, 8'h80));
    rows.push_back(send_row(32'hffff_fff0, 8'h7f));
    rows.push_back(recv_row(32'd1700, 16'd32841, 16'd256, 32'd0));
    rows.push_back(recv_row(32'd5, 16'd32842, 16'd5, 32'h0000_000f));
    rows.push_back(recv_row(32'd6, 16'hffff, 16'hffff, 32'h8000_0000));
    rows.push_back(send_row(32'd10, 8'haa));
    rows.push_back(recv_row(32'd20, 16'h0000, 16'd6, 32'd0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[k]) drive_item(rows[k]);

    clock_ticks = 32'd100;
    for (int k = 0; k < N_RANDOM; k++) begin
      calm = (k >= N_RANDOM - N_CALM);
      if ($urandom_range(0, 9) == 0) clock_ticks = $urandom;
      else clock_ticks = clock_ticks + $urandom_range(0, 600);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        drive_item(send_row(clock_ticks, TYPE_W'($urandom_range(0, 255))));
      end else if (pick < 92) begin
        // plausible peer: near window, acking recent sends
        if ($urandom_range(0, 4) == 0) rs = SEQ_W'($urandom);
        else rs = peer_seq + SEQ_W'($urandom_range(0, 80)) - 16'd40;
        if ($urandom_range(0, 7) == 0) ra = SEQ_W'($urandom);
        else ra = tx_seq - 16'd1 - SEQ_W'($urandom_range(0, 4));
        case ($urandom_range(0, 3))
          0: m = 32'hffff_ffff;
          1: m = $urandom & $urandom;
          default: m = $urandom;
        endcase
        drive_item(recv_row(clock_ticks, rs, ra, m));
      end else begin
        drive_item(recv_row($urandom, SEQ_W'($urandom), SEQ_W'($urandom), $urandom));
      end
    end
    in_tvalid = 1'b0;

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (n_errors == 0 && pending_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/pabt_pkg.sv
hw/rtl/pabt_ctrl.sv
hw/rtl/pabt_dp.sv
hw/rtl/packet_ack_bitfield_tracker_core.sv
tb/tb_packet_ack_bitfield_tracker_core.sv
